@@ hw/rtl/skh_pkg.sv @@
// Shared types, constants and byte decoding for the sampled k-mer seed hasher.
package skh_pkg;

	localparam int unsigned BYTE_W   = 8;
	localparam int unsigned KLEN_W   = 6;
	localparam int unsigned KEY_W    = 29;
	localparam int unsigned POS_W    = 32;
	localparam int unsigned WIN_W    = 64;
	localparam int unsigned RUN_W    = 6;
	localparam int unsigned CODE_W   = 3;
	localparam int unsigned OUT_W    = 64;

	localparam logic [KEY_W-1:0]  KEY_MOD  = 29'h1FFF_FFFF;
	localparam logic [RUN_W-1:0]  RUN_CAP  = 6'd32;
	localparam logic [KLEN_W-1:0] KLEN_MAX = 6'd32;
	localparam logic [KLEN_W-1:0] KLEN_MIN = 6'd1;
	localparam logic [KLEN_W-1:0] KLEN_RST = 6'd31;

	localparam logic [BYTE_W-1:0] CH_LF    = 8'd10;
	localparam logic [BYTE_W-1:0] CH_HDR   = 8'h3E;
	localparam logic [BYTE_W-1:0] CH_LOW   = 8'd33;
	localparam logic [BYTE_W-1:0] CH_HIGH  = 8'd127;
	localparam logic [BYTE_W-1:0] CH_UA    = 8'h41;
	localparam logic [BYTE_W-1:0] CH_LA    = 8'h61;
	localparam logic [BYTE_W-1:0] CH_UC    = 8'h43;
	localparam logic [BYTE_W-1:0] CH_LC    = 8'h63;
	localparam logic [BYTE_W-1:0] CH_UG    = 8'h47;
	localparam logic [BYTE_W-1:0] CH_LG    = 8'h67;
	localparam logic [BYTE_W-1:0] CH_UT    = 8'h54;
	localparam logic [BYTE_W-1:0] CH_LT    = 8'h74;

	localparam logic [CODE_W-1:0] CODE_A   = 3'd0;
	localparam logic [CODE_W-1:0] CODE_C   = 3'd1;
	localparam logic [CODE_W-1:0] CODE_G   = 3'd2;
	localparam logic [CODE_W-1:0] CODE_T   = 3'd3;
	localparam logic [CODE_W-1:0] CODE_BAD = 3'd4;

	// Stage-one seed candidate handed from the parser to the key fold.
	typedef struct packed {
		logic             valid;
		logic [WIN_W-1:0] win;
		logic [POS_W-1:0] start;
	} seed_s1_t;

	function automatic logic [CODE_W-1:0] base_code(input logic [BYTE_W-1:0] b);
		logic [CODE_W-1:0] c;
		case (b)
			CH_UA, CH_LA: c = CODE_A;
			CH_UC, CH_LC: c = CODE_C;
			CH_UG, CH_LG: c = CODE_G;
			CH_UT, CH_LT: c = CODE_T;
			default:      c = CODE_BAD;
		endcase
		return c;
	endfunction

endpackage

@@ hw/rtl/skh_key_fold.sv @@
// Reduction of a 64-bit packed window modulo 2^29-1 by end-around folding.
module skh_key_fold import skh_pkg::*; (
	input  logic [WIN_W-1:0] win,
	output logic [KEY_W-1:0] key
);

	logic [KEY_W+1:0] sum_a;
	logic [KEY_W:0]   sum_b;

	always_comb begin
		// 2^29 == 1 mod the key modulus: add the 29-bit chunks together
		sum_a = {2'b00, win[28:0]} + {2'b00, win[57:29]} + {25'd0, win[63:58]};
		sum_b = {1'b0, sum_a[KEY_W-1:0]} + {28'd0, sum_a[KEY_W+1:KEY_W]};
		if (sum_b >= {1'b0, KEY_MOD}) begin
			key = KEY_W'(sum_b - {1'b0, KEY_MOD});
		end else begin
			key = sum_b[KEY_W-1:0];
		end
	end

endmodule

@@ hw/rtl/skh_parse.sv @@
// Text parser: line state, base window, run count, sampling test and stage-one register.
module skh_parse import skh_pkg::*; #(
	parameter int unsigned SAMPLE_STEP = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  logic              load_s1,
	input  logic [BYTE_W-1:0] text_byte,
	input  logic [KLEN_W-1:0] kmer_length,
	output seed_s1_t          seed_s1
);

	localparam int unsigned XW = $clog2(SAMPLE_STEP) + 2;
	localparam logic [XW-1:0] STEP     = XW'(SAMPLE_STEP);
	localparam logic [XW-1:0] STEP_TOP = XW'(SAMPLE_STEP - 1);
	localparam logic [XW-1:0] WRAP_REM = XW'((64'd1 << 32) % SAMPLE_STEP);

	logic             line_start_q;
	logic             in_hdr_q;
	logic [POS_W-1:0] pos_q;
	logic [XW-1:0]    phase_q;
	logic [WIN_W-1:0] win_q;
	logic [RUN_W-1:0] run_q;

	logic             line_start_d;
	logic             in_hdr_d;
	logic [POS_W-1:0] pos_d;
	logic [XW-1:0]    phase_d;
	logic [WIN_W-1:0] win_d;
	logic [RUN_W-1:0] run_d;

	logic              is_lf;
	logic              is_base;
	logic [CODE_W-1:0] code;
	logic              code_ok;
	logic [KLEN_W-1:0] klen;
	logic [4:0]        kmin1;
	logic [XW-1:0]     rem_k;
	logic [XW-1:0]     x1;
	logic [XW-1:0]     x2;
	logic              borrow;
	logic [WIN_W-1:0]  mask;
	logic              hit;

	logic              valid_s1;
	logic [WIN_W-1:0]  win_s1;
	logic [POS_W-1:0]  start_s1;

	// Remainder of a small count by the sample step, as a lookup
	function automatic logic [XW-1:0] rem_small(input logic [4:0] v);
		logic [XW-1:0] r;
		r = '0;
		for (int i = 0; i < 32; i++) begin
			if (v == 5'(i)) begin
				r = XW'(i % SAMPLE_STEP);
			end
		end
		return r;
	endfunction

	always_comb begin
		is_lf   = (text_byte == CH_LF);
		is_base = !is_lf && !(line_start_q && text_byte == CH_HDR) && !in_hdr_q &&
			(text_byte >= CH_LOW) && (text_byte <= CH_HIGH);
		code    = base_code(text_byte);
		code_ok = (code != CODE_BAD);

		line_start_d = is_lf;
		if (is_lf) begin
			in_hdr_d = 1'b0;
		end else if (line_start_q && text_byte == CH_HDR) begin
			in_hdr_d = 1'b1;
		end else begin
			in_hdr_d = in_hdr_q;
		end

		pos_d = pos_q + 32'd1;
		if (pos_q == '1 || phase_q == STEP_TOP) begin
			phase_d = '0;
		end else begin
			phase_d = phase_q + XW'(1);
		end

		if (code_ok) begin
			win_d = {win_q[WIN_W-3:0], code[1:0]};
			run_d = (run_q < RUN_CAP) ? run_q + 6'd1 : run_q;
		end else begin
			win_d = {win_q[WIN_W-3:0], 2'b00};
			run_d = '0;
		end

		// Clamp the window length into 1..32
		if (kmer_length == '0) begin
			klen = KLEN_MIN;
		end else if (kmer_length > KLEN_MAX) begin
			klen = KLEN_MAX;
		end else begin
			klen = kmer_length;
		end
		kmin1 = 5'(klen - KLEN_MIN);

		// Start phase = (pos - (k-1)) mod step, with the 2^32 wrap folded back in
		rem_k  = rem_small(kmin1);
		borrow = (pos_q < {27'd0, kmin1});
		x1     = phase_q + STEP - rem_k;
		if (x1 >= STEP) begin
			x1 = x1 - STEP;
		end
		x2 = x1;
		if (borrow) begin
			x2 = x1 + WRAP_REM;
			if (x2 >= STEP) begin
				x2 = x2 - STEP;
			end
		end

		mask = {WIN_W{1'b1}} >> (7'd64 - {klen, 1'b0});
		hit  = is_base && code_ok && (run_d >= klen) && (x2 == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_start_q <= 1'b1;
			in_hdr_q     <= 1'b0;
			pos_q        <= '0;
			phase_q      <= '0;
			win_q        <= '0;
			run_q        <= '0;
		end else if (accept) begin
			line_start_q <= line_start_d;
			in_hdr_q     <= in_hdr_d;
			if (is_base) begin
				pos_q   <= pos_d;
				phase_q <= phase_d;
				win_q   <= win_d;
				run_q   <= run_d;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load_s1) begin
			valid_s1 <= accept && hit;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			win_s1   <= win_d & mask;
			start_s1 <= pos_q - {27'd0, kmin1};
		end
	end

	assign seed_s1 = '{valid: valid_s1, win: win_s1, start: start_s1};

`ifndef SYNTHESIS
	a_run_cap: assert property (@(posedge clk) disable iff (!arst_n)
		run_q <= RUN_CAP) else $error("valid run above cap");
	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q < STEP) else $error("position phase out of range");
	a_hdr_not_start: assert property (@(posedge clk) disable iff (!arst_n)
		in_hdr_q |-> !line_start_q) else $error("header flag set at line start");
`endif

endmodule

@@ hw/rtl/sampled_kmer_seed_hasher_core.sv @@
// A seed is held in the stage-one register, then in the result register that drives m_tvalid.
// Throughput: one text byte per cycle while s_tready is high; the result register advances whenever it is empty
//   or being taken, and the stage-one register whenever it is empty or the result advances.
// The key is a three-chunk fold modulo 2^29-1 between the two registers.
// Reset (arst_n low) clears line state, position, window, run count and both
//   valid flags, and sets kmer_length to 31.
module sampled_kmer_seed_hasher_core import skh_pkg::*; #(
	parameter int unsigned SAMPLE_STEP = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [BYTE_W-1:0] s_tdata,   // [7:0] text_byte
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [OUT_W-1:0]  m_tdata,   // [28:0] seed_key, [60:29] seed_pos, [63:61] zero
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [KLEN_W-1:0] cfg_data   // [5:0] kmer_length
);

	logic [KLEN_W-1:0] kmer_length_q;
	seed_s1_t          seed_s1;
	logic [KEY_W-1:0]  key;
	logic              out_v_q;
	logic [KEY_W-1:0]  key_q;
	logic [POS_W-1:0]  pos_q;
	logic              adv;
	logic              load_s1;
	logic              accept;

	// Output register advances when empty or drained this cycle
	assign adv      = !out_v_q || m_tready;
	// Stage one takes a new item when empty or moving into the output register
	assign load_s1  = !seed_s1.valid || adv;
	assign s_tready = load_s1;
	assign accept   = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;

	// Hold the window length; the user must write it only while idle, the block does not enforce this
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kmer_length_q <= KLEN_RST;
		end else if (cfg_valid && cfg_ready) begin
			kmer_length_q <= cfg_data;
		end
	end

	skh_parse #(
		.SAMPLE_STEP(SAMPLE_STEP)
	) u_parse (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.load_s1    (load_s1),
		.text_byte  (s_tdata),
		.kmer_length(kmer_length_q),
		.seed_s1    (seed_s1)
	);

	skh_key_fold u_fold (
		.win(seed_s1.win),
		.key(key)
	);

	// Result register: advance the stage-one candidate, drop empty slots
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (adv) begin
			out_v_q <= seed_s1.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			key_q <= key;
			pos_q <= seed_s1.start;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = {3'b000, pos_q, key_q};

`ifndef SYNTHESIS
	a_key_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[KEY_W-1:0] < KEY_MOD)) else $error("seed key not reduced");
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(seed_s1.valid && m_tvalid && !m_tready) |-> !s_tready)
		else $error("input taken with both stages full");
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && !seed_s1.valid) |=> !m_tvalid)
		else $error("result repeated after drain");
`endif

endmodule
